// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// ASSERT_RST expects signals named clk and rst_n in the calling scope, ASSERT_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== src/mtcg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtcg_pkg
// Types and constants for the MIDI time code message generator.
// ----------------------------------------------------------------------------
package mtcg_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_CODE         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_FRAME = 2'd1;

    localparam int unsigned CFG_DATA_W = 16;

    // Function codes of an input item
    localparam logic FUNC_FULL_FRAME    = 1'b0;
    localparam logic FUNC_QUARTER_FRAME = 1'b1;

    // Frame rate codes
    localparam logic [1:0] RATE_24      = 2'd0;
    localparam logic [1:0] RATE_25      = 2'd1;
    localparam logic [1:0] RATE_30_DROP = 2'd2;
    localparam logic [1:0] RATE_30      = 2'd3;

    // Reset values of the registers
    localparam logic [1:0]  RATE_CODE_RST         = RATE_25;
    localparam logic [15:0] SAMPLES_PER_FRAME_RST = 16'd1920;

    // MIDI bytes
    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;
    localparam logic [7:0] SYSEX_RT_ID    = 8'h7F;
    localparam logic [7:0] SYSEX_ALL_DEV  = 8'h7F;
    localparam logic [7:0] SYSEX_SUB_MTC  = 8'h01;
    localparam logic [7:0] SYSEX_FULL_MSG = 8'h01;
    localparam logic [7:0] QF_STATUS      = 8'hF1;

    // Last byte index of one item's output
    localparam logic [3:0] FULL_LAST_IDX = 4'd9;
    localparam logic [3:0] QF_LAST_IDX   = 4'd7;

    // Configuration seen by front and back
    typedef struct packed {
        logic [1:0]  rate_code;
        logic [15:0] samples_per_frame;
    } mtcg_cfg_t;

    // Work passed from the front to the back through the queue
    typedef struct packed {
        logic        quarter;   // 1: quarter-frame messages, 0: full-frame sysex
        logic        half;      // quarter-frame pieces 4..7 instead of 0..3
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [4:0]  frames;
        logic [47:0] position;
    } mtcg_cmd_t;

endpackage
`default_nettype wire

// ===== src/mtcg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtcg_front
// Accepts input items, keeps the quarter-frame piece state and the held
// timecode, and queues one command per item that produces output.
// ----------------------------------------------------------------------------
module mtcg_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic [4:0]         hours,
    input  wire logic [5:0]         minutes,
    input  wire logic [5:0]         seconds,
    input  wire logic [4:0]         frames,
    input  wire logic [47:0]        position,
    input  wire mtcg_pkg::mtcg_cfg_t cfg,
    output logic                    push,
    output mtcg_pkg::mtcg_cmd_t     push_data,
    input  wire logic               queue_full
);
    import mtcg_pkg::*;

    logic       half_reg, half_next;
    logic [4:0] held_hours_reg, held_hours_next;
    logic [5:0] held_minutes_reg, held_minutes_next;
    logic [5:0] held_seconds_reg, held_seconds_next;
    logic [4:0] held_frames_reg, held_frames_next;
    logic       accept;
    logic       odd_skip;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    // Odd frame at the first piece is skipped unless running at 25 fps
    assign odd_skip = !half_reg && (cfg.rate_code != RATE_25) && frames[0];

    always_comb
    begin
        half_next         = half_reg;
        held_hours_next   = held_hours_reg;
        held_minutes_next = held_minutes_reg;
        held_seconds_next = held_seconds_reg;
        held_frames_next  = held_frames_reg;
        push              = 1'b0;
        push_data.quarter  = func;
        push_data.half     = half_reg;
        push_data.hours    = hours;
        push_data.minutes  = minutes;
        push_data.seconds  = seconds;
        push_data.frames   = frames;
        push_data.position = position;
        if (accept)
        begin
            if (func == FUNC_FULL_FRAME)
            begin
                push = 1'b1;
            end
            else if (!odd_skip)
            begin
                push      = 1'b1;
                half_next = !half_reg;
                if (!half_reg)
                begin
                    held_hours_next   = hours;
                    held_minutes_next = minutes;
                    held_seconds_next = seconds;
                    held_frames_next  = frames;
                end
                else
                begin
                    push_data.hours   = held_hours_reg;
                    push_data.minutes = held_minutes_reg;
                    push_data.seconds = held_seconds_reg;
                    push_data.frames  = held_frames_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg         <= 1'b0;
            held_hours_reg   <= '0;
            held_minutes_reg <= '0;
            held_seconds_reg <= '0;
            held_frames_reg  <= '0;
        end
        else
        begin
            half_reg         <= half_next;
            held_hours_reg   <= held_hours_next;
            held_minutes_reg <= held_minutes_next;
            held_seconds_reg <= held_seconds_next;
            held_frames_reg  <= held_frames_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/mtcg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtcg_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mtcg_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mtcg_pkg::mtcg_cmd_t push_data,
    input  wire logic               pop,
    output mtcg_pkg::mtcg_cmd_t     pop_data,
    output logic                    full,
    output logic                    empty
);
    import mtcg_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mtcg_cmd_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_RST(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `ASSERT_RST(a_no_overflow, full |-> !push)
    `ASSERT_RST(a_no_underflow, empty |-> !pop)
    `ASSERT_RST(a_count_track, (push && !pop && !full) |=> !empty)

endmodule
`default_nettype wire

// ===== src/mtcg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtcg_back
// Walks one queued command byte by byte into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mtcg_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mtcg_pkg::mtcg_cfg_t cfg,
    input  wire mtcg_pkg::mtcg_cmd_t cmd,
    input  wire logic               cmd_empty,
    output logic                    cmd_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              midi_byte,
    output logic [47:0]             stamp,
    output logic                    message_end,
    output logic                    last
);
    import mtcg_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic [47:0] stamp_reg;
    logic        mend_reg;
    logic        last_reg;

    logic        advance;
    logic        fire;
    logic        is_last;
    logic [6:0]  hr_code;
    logic [2:0]  piece;
    logic [1:0]  msg_num;
    logic [17:0] off_prod;
    logic [7:0]  byte_cur;
    logic [47:0] stamp_cur;
    logic        mend_cur;

    assign advance = !out_valid_reg || !out_stall;
    assign fire    = advance && !cmd_empty;
    assign is_last = cmd.quarter ? (idx_reg == QF_LAST_IDX) : (idx_reg == FULL_LAST_IDX);
    assign cmd_pop = fire && is_last;
    assign hr_code = {cfg.rate_code, cmd.hours};
    assign msg_num = idx_reg[2:1];
    assign piece   = {cmd.half, msg_num};

    // i * samples_per_frame for message i in 0..3, then floor divide by 4
    assign off_prod = ({2'b00, cfg.samples_per_frame} & {18{msg_num[0]}})
                    + ({1'b0, cfg.samples_per_frame, 1'b0} & {18{msg_num[1]}});

    always_comb
    begin
        byte_cur  = SYSEX_END;
        stamp_cur = cmd.position;
        mend_cur  = is_last;
        if (cmd.quarter)
        begin
            stamp_cur = cmd.position + {32'd0, off_prod[17:2]};
            mend_cur  = idx_reg[0];
            if (!idx_reg[0])
                byte_cur = QF_STATUS;
            else
            begin
                case (piece)
                    3'd0:    byte_cur = {1'b0, piece, cmd.frames[3:0]};
                    3'd1:    byte_cur = {1'b0, piece, 3'b000, cmd.frames[4]};
                    3'd2:    byte_cur = {1'b0, piece, cmd.seconds[3:0]};
                    3'd3:    byte_cur = {1'b0, piece, 2'b00, cmd.seconds[5:4]};
                    3'd4:    byte_cur = {1'b0, piece, cmd.minutes[3:0]};
                    3'd5:    byte_cur = {1'b0, piece, 2'b00, cmd.minutes[5:4]};
                    3'd6:    byte_cur = {1'b0, piece, hr_code[3:0]};
                    default: byte_cur = {1'b0, piece, 1'b0, hr_code[6:4]};
                endcase
            end
        end
        else
        begin
            case (idx_reg)
                4'd0:    byte_cur = SYSEX_START;
                4'd1:    byte_cur = SYSEX_RT_ID;
                4'd2:    byte_cur = SYSEX_ALL_DEV;
                4'd3:    byte_cur = SYSEX_SUB_MTC;
                4'd4:    byte_cur = SYSEX_FULL_MSG;
                4'd5:    byte_cur = {1'b0, hr_code};
                4'd6:    byte_cur = {2'b00, cmd.minutes};
                4'd7:    byte_cur = {2'b00, cmd.seconds};
                4'd8:    byte_cur = {3'b000, cmd.frames};
                default: byte_cur = SYSEX_END;
            endcase
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (fire)
            idx_next = is_last ? 4'd0 : idx_reg + 4'd1;
        if (advance)
            out_valid_next = fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg  <= byte_cur;
            stamp_reg <= stamp_cur;
            mend_reg  <= mend_cur;
            last_reg  <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign midi_byte   = byte_reg;
    assign stamp       = stamp_reg;
    assign message_end = mend_reg;
    assign last        = last_reg;

    `ASSERT_RST(a_idx_bound, idx_reg <= FULL_LAST_IDX)
    `ASSERT_RST(a_last_ends_msg, (out_valid_reg && last_reg) |-> mend_reg)
    `ASSERT_RST(a_qf_data_byte, (out_valid_reg && mend_reg && !last_reg) |-> !byte_reg[7])
    `ASSERT_RST(a_pop_restarts, cmd_pop |=> (idx_reg == 4'd0))

endmodule
`default_nettype wire

// ===== src/midi_timecode_message_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// midi_timecode_message_generator_unit
// Turns timecode frame items into MIDI full-frame or quarter-frame bytes.
// ----------------------------------------------------------------------------
// Output: the first byte of an item is registered after the item passes
//   through the queue, once the output register is empty or being taken.
// Throughput: one byte per cycle from the output sequencer while out_stall is
//   low; a full-frame item gives 10 bytes, a quarter-frame item 8, a skipped odd frame none.
// Reset: rst_n clears the piece index, held timecode, queue and output valid;
//   rate_code returns to 1 (25 fps) and samples_per_frame to 1920.
// ----------------------------------------------------------------------------
module midi_timecode_message_generator_unit #(
    parameter int unsigned QUEUE_DEPTH = 2    // commands buffered between stages
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              func,
    input  wire logic [4:0]                        hours,
    input  wire logic [5:0]                        minutes,
    input  wire logic [5:0]                        seconds,
    input  wire logic [4:0]                        frames,
    input  wire logic [47:0]                       position,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [7:0]                             midi_byte,
    output logic [47:0]                            stamp,
    output logic                                   message_end,
    output logic                                   last,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mtcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mtcg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mtcg_pkg::*;

    // Configuration registers. Writes are always taken; an unknown index
    // is dropped. Software only writes while the block is idle; the block does not enforce it.
    logic [1:0]  rate_code_reg, rate_code_next;
    logic [15:0] spf_reg, spf_next;
    mtcg_cfg_t   cfg;

    // Front-to-back command path
    logic       push;
    mtcg_cmd_t  push_data;
    logic       pop;
    mtcg_cmd_t  head;
    logic       queue_full;
    logic       queue_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rate_code_next = rate_code_reg;
        spf_next       = spf_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RATE_CODE:         rate_code_next = cfg_data[1:0];
                REG_SAMPLES_PER_FRAME: spf_next       = cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_code_reg <= RATE_CODE_RST;
            spf_reg       <= SAMPLES_PER_FRAME_RST;
        end
        else
        begin
            rate_code_reg <= rate_code_next;
            spf_reg       <= spf_next;
        end
    end

    assign cfg.rate_code         = rate_code_reg;
    assign cfg.samples_per_frame = spf_reg;

    // Front: takes every item while the queue has room, tracks which half
    // of the eight quarter-frame pieces is next, latches the timecode at the
    // first half and drops odd frames there at non-25 rates.
    mtcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .hours      (hours),
        .minutes    (minutes),
        .seconds    (seconds),
        .frames     (frames),
        .position   (position),
        .cfg        (cfg),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Queue: lets the input keep flowing while the back end sends bytes
    mtcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back: byte sequencer with a registered output stage; it moves on
    // whenever the output register is empty or being taken.
    mtcg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (head),
        .cmd_empty   (queue_empty),
        .cmd_pop     (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .midi_byte   (midi_byte),
        .stamp       (stamp),
        .message_end (message_end),
        .last        (last)
    );

endmodule
`default_nettype wire
